@@ rtl/slsfr_pkg.sv @@
// package for the sync length sum frame receiver
// holds field widths, command codes, status codes and the command and result record types
// no dependencies
package slsfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int SUM_W           = 16;
    localparam int MAX_FRAME_BYTES = 255;
    localparam int MIN_FRAME_BYTES = 9;
    localparam int HEADER_BYTES    = 7;

    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hFE;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hEF;

    localparam logic [BYTE_W-1:0] KIND_A = 8'h00;
    localparam logic [BYTE_W-1:0] KIND_B = 8'h10;
    localparam logic [BYTE_W-1:0] KIND_C = 8'h11;

    // commands handed from front to back
    typedef logic [2:0] t_op;
    localparam t_op OP_START   = 3'd0;
    localparam t_op OP_ADD     = 3'd1;
    localparam t_op OP_LEN_ERR = 3'd2;
    localparam t_op OP_INDEX   = 3'd3;
    localparam t_op OP_KIND    = 3'd4;
    localparam t_op OP_PAYLOAD = 3'd5;
    localparam t_op OP_SUMLO   = 3'd6;
    localparam t_op OP_SUMHI   = 3'd7;

    typedef logic [1:0] t_status;
    localparam t_status ST_GOOD    = 2'd0;
    localparam t_status ST_SUM_ERR = 2'd1;
    localparam t_status ST_UNKNOWN = 2'd2;
    localparam t_status ST_LEN_ERR = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] offset;
    } t_cmd;

    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_offset;
        logic [BYTE_W-1:0] message_kind;
        logic [BYTE_W-1:0] frame_number;
        t_status           status;
        logic              last;
    } t_res;

endpackage

@@ rtl/slsfr_if.sv @@
// channel interfaces of the frame receiver: received bytes, results, config writes
// depends on slsfr_pkg
interface slsfr_rx_if import slsfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slsfr_res_if import slsfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              item_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_offset;
    logic [BYTE_W-1:0] message_kind;
    logic [BYTE_W-1:0] frame_number;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, output item_kind, output payload_byte,
                    output payload_offset, output message_kind, output frame_number,
                    output status, output last, input ready);
    modport sink (input valid, input item_kind, input payload_byte,
                  input payload_offset, input message_kind, input frame_number,
                  input status, input last, output ready);
endinterface

interface slsfr_cfg_if import slsfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sync_length_sum_frame_receiver.sv @@
// top level of the sync length sum frame receiver: front, command queue, back
// path: an accepted frame byte goes into the command queue, then popped by the back end into the result register
// throughput: one byte per cycle while the result side is ready, set by the one-command-per-cycle back end
// reset: synchronous active low; hunt restarts, sync pattern returns to fe ef
// depends on slsfr_pkg, slsfr_if, slsfr_front, slsfr_queue, slsfr_back
module sync_length_sum_frame_receiver import slsfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slsfr_rx_if.sink    i_rx,
    slsfr_cfg_if.sink   i_cfg,
    slsfr_res_if.source o_res
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    slsfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    slsfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (q_empty)
    );

    slsfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

@@ rtl/slsfr_front.sv @@
// front end: sync hunt, header parse and byte classification into commands
// holds the sync pattern registers; depends on slsfr_pkg and slsfr_if
module slsfr_front import slsfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slsfr_rx_if.sink   i_rx,
    slsfr_cfg_if.sink  i_cfg,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_LEN     = 4'd2;
    localparam logic [3:0] PH_INDEX   = 4'd3;
    localparam logic [3:0] PH_SYS     = 4'd4;
    localparam logic [3:0] PH_MOD     = 4'd5;
    localparam logic [3:0] PH_KIND    = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_SUMLO   = 4'd8;
    localparam logic [3:0] PH_SUMHI   = 4'd9;

    localparam logic [BYTE_W-1:0] MIN_LEN = BYTE_W'(MIN_FRAME_BYTES);
    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME_BYTES);
    localparam logic [BYTE_W-1:0] HDR_LEN = BYTE_W'(HEADER_BYTES);

    logic [3:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_sync_first, r_sync_second;
    logic              accept;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] count_inc;

    assign i_rx.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid && !i_q_full;
    assign b           = i_rx.rx_byte;
    assign count_inc   = r_count + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        o_push  = 1'b0;
        o_cmd   = '{op: OP_ADD, data: b, offset: '0};
        if (accept) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (b == r_sync_first) begin
                        o_push    = 1'b1;
                        o_cmd.op  = OP_START;
                        n_count   = 8'd1;
                        n_phase   = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (b == r_sync_second) begin
                        o_push  = 1'b1;
                        n_count = count_inc;
                        n_phase = PH_LEN;
                    end else if (b == r_sync_first) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_START;
                        n_count  = 8'd1;
                    end else begin
                        n_count = '0;
                        n_phase = PH_HUNT1;
                    end
                end
                PH_LEN: begin
                    o_push = 1'b1;
                    if (b < MIN_LEN || b > MAX_LEN) begin
                        o_cmd.op = OP_LEN_ERR;
                        n_count  = '0;
                        n_len    = '0;
                        n_phase  = PH_HUNT1;
                    end else begin
                        n_len   = b;
                        n_count = count_inc;
                        n_phase = PH_INDEX;
                    end
                end
                PH_INDEX: begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_INDEX;
                    n_count  = count_inc;
                    n_phase  = PH_SYS;
                end
                PH_SYS: begin
                    o_push  = 1'b1;
                    n_count = count_inc;
                    n_phase = PH_MOD;
                end
                PH_MOD: begin
                    o_push  = 1'b1;
                    n_count = count_inc;
                    n_phase = PH_KIND;
                end
                PH_KIND: begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_KIND;
                    n_count  = count_inc;
                    n_phase  = (r_len == MIN_LEN) ? PH_SUMLO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_push       = 1'b1;
                    o_cmd.op     = OP_PAYLOAD;
                    o_cmd.offset = r_count - HDR_LEN;
                    n_count      = count_inc;
                    if ({1'b0, r_count} + 9'd3 >= {1'b0, r_len}) begin
                        n_phase = PH_SUMLO;
                    end
                end
                PH_SUMLO: begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_SUMLO;
                    n_phase  = PH_SUMHI;
                end
                PH_SUMHI: begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_SUMHI;
                    n_count  = '0;
                    n_len    = '0;
                    n_phase  = PH_HUNT1;
                end
                default: begin
                    n_count = '0;
                    n_len   = '0;
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT1;
            r_count       <= '0;
            r_len         <= '0;
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg.data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/slsfr_queue.sv @@
// short command queue between front and back
// depends on slsfr_pkg
module slsfr_queue import slsfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_pop_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_mem[r_rd_ptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/slsfr_back.sv @@
// back end: running sum, held header fields, checksum and message kind check and result register
// depends on slsfr_pkg and slsfr_if
module slsfr_back import slsfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    output logic        o_pop,
    slsfr_res_if.source o_res
);

    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [BYTE_W-1:0] r_sum_lo, n_sum_lo;
    logic [BYTE_W-1:0] r_kind, n_kind;
    logic [BYTE_W-1:0] r_index, n_index;
    logic [SUM_W-1:0]  sum_add;
    logic [SUM_W-1:0]  got_sum;
    logic              kind_known;

    assign o_pop      = !i_empty && (!r_out_valid || o_res.ready);
    assign sum_add    = r_sum + {{(SUM_W-BYTE_W){1'b0}}, i_cmd.data};
    assign got_sum    = {i_cmd.data, r_sum_lo};
    assign kind_known = (r_kind == KIND_A) || (r_kind == KIND_B) || (r_kind == KIND_C);

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        n_sum       = r_sum;
        n_sum_lo    = r_sum_lo;
        n_kind      = r_kind;
        n_index     = r_index;
        if (o_pop) begin
            case (i_cmd.op)
                OP_START: begin
                    n_sum = {{(SUM_W-BYTE_W){1'b0}}, i_cmd.data};
                end
                OP_ADD: begin
                    n_sum = sum_add;
                end
                OP_INDEX: begin
                    n_sum   = sum_add;
                    n_index = i_cmd.data;
                end
                OP_KIND: begin
                    n_sum  = sum_add;
                    n_kind = i_cmd.data;
                end
                OP_PAYLOAD: begin
                    n_sum       = sum_add;
                    n_out_valid = 1'b1;
                    n_out       = '{item_kind: KIND_PAYLOAD, payload_byte: i_cmd.data,
                                    payload_offset: i_cmd.offset, message_kind: r_kind,
                                    frame_number: r_index, status: ST_GOOD, last: 1'b0};
                end
                OP_SUMLO: begin
                    n_sum_lo = i_cmd.data;
                end
                OP_SUMHI: begin
                    n_out_valid = 1'b1;
                    n_out       = '{item_kind: KIND_STATUS, payload_byte: '0,
                                    payload_offset: '0, message_kind: r_kind,
                                    frame_number: r_index, status: ST_GOOD, last: 1'b1};
                    if (got_sum != r_sum) begin
                        n_out.status = ST_SUM_ERR;
                    end else if (!kind_known) begin
                        n_out.status = ST_UNKNOWN;
                    end
                    n_sum    = '0;
                    n_sum_lo = '0;
                    n_kind   = '0;
                    n_index  = '0;
                end
                OP_LEN_ERR: begin
                    n_out_valid = 1'b1;
                    n_out       = '{item_kind: KIND_STATUS, payload_byte: '0,
                                    payload_offset: '0, message_kind: '0,
                                    frame_number: '0, status: ST_LEN_ERR, last: 1'b1};
                    n_sum    = '0;
                    n_sum_lo = '0;
                    n_kind   = '0;
                    n_index  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_sum_lo    <= '0;
            r_kind      <= '0;
            r_index     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_sum_lo    <= n_sum_lo;
            r_kind      <= n_kind;
            r_index     <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.item_kind      = r_out.item_kind;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.payload_offset = r_out.payload_offset;
    assign o_res.message_kind   = r_out.message_kind;
    assign o_res.frame_number   = r_out.frame_number;
    assign o_res.status         = r_out.status;
    assign o_res.last           = r_out.last;

endmodule

@@ sim/sync_length_sum_frame_receiver_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for sync_length_sum_frame_receiver: a short directed byte table, then
// random frames under several sync patterns; an in-bench decoder or a pinned row gives each
// expected result; depends on slsfr_pkg, slsfr_if and the rtl top level
module sync_length_sum_frame_receiver_test;
    import slsfr_pkg::*;

    localparam int BYTES_PER_SETTING = 360;
    localparam int SETTINGS_RUN      = 5;
    localparam int WATCHDOG_CYCLES   = 4000;
    localparam int DRAIN_CYCLES      = 6;
    localparam int DIRECTED_ROWS     = 25;

    localparam t_res NO_RES      = '0;
    localparam t_res LEN_ERR_RES = '{KIND_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, ST_LEN_ERR, 1'b1};
    localparam t_res EMPTY_RES   = '{KIND_STATUS, 8'h00, 8'h00, KIND_B, 8'h07, ST_GOOD, 1'b1};
    localparam t_res SUM_ERR_RES = '{KIND_STATUS, 8'h00, 8'h00, 8'hFF, 8'hFF, ST_SUM_ERR, 1'b1};

    typedef enum logic [3:0] {
        HUNT_FIRST, HUNT_SECOND, GET_LEN, GET_INDEX, GET_SYS, GET_MOD, GET_KIND,
        GET_PAYLOAD, GET_SUM_LO, GET_SUM_HI
    } t_rx_phase;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} t_ready_mode;

    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        bit                pinned;
        t_res              want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    slsfr_rx_if  rx_ch();
    slsfr_cfg_if cfg_ch();
    slsfr_res_if res_ch();

    sync_length_sum_frame_receiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // decoder copy of the block
    logic [BYTE_W-1:0] sync_first_q;
    logic [BYTE_W-1:0] sync_second_q;
    t_rx_phase         dec_phase;
    logic [BYTE_W-1:0] dec_count;
    logic [BYTE_W-1:0] dec_length;
    logic [SUM_W-1:0]  dec_sum;
    logic [BYTE_W-1:0] dec_sum_lo;
    logic [BYTE_W-1:0] dec_kind;
    logic [BYTE_W-1:0] dec_index;

    t_res pending_results[$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;

    bit          row_pinned;
    t_res        row_want;
    int          burst_left = 0;
    int          bytes_sent = 0;
    t_ready_mode ready_mode = READY_ALWAYS;
    int          ready_left = 0;
    logic [2:0]  ready_tick = '0;

    t_row              directed_rows [DIRECTED_ROWS];
    logic [BYTE_W-1:0] first_vals [SETTINGS_RUN];
    logic [BYTE_W-1:0] second_vals [SETTINGS_RUN];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic void clear_frame();
        dec_phase  = HUNT_FIRST;
        dec_count  = '0;
        dec_length = '0;
        dec_sum    = '0;
        dec_sum_lo = '0;
        dec_kind   = '0;
        dec_index  = '0;
    endfunction

    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        dec_sum   = dec_sum + SUM_W'(b);
        dec_count = dec_count + 8'd1;
    endfunction

    task automatic frame_step(input logic [BYTE_W-1:0] b, input bit pin, input t_res want);
        t_res             res;
        bit               produced;
        logic [SUM_W-1:0] got_sum;
        res      = '0;
        produced = 1'b0;
        case (dec_phase)
            HUNT_FIRST: begin
                if (b == sync_first_q) begin
                    dec_sum   = SUM_W'(b);
                    dec_count = 8'd1;
                    dec_phase = HUNT_SECOND;
                end
            end
            HUNT_SECOND: begin
                if (b == sync_second_q) begin
                    add_byte(b);
                    dec_phase = GET_LEN;
                end else if (b == sync_first_q) begin
                    dec_sum   = SUM_W'(b);
                    dec_count = 8'd1;
                end else begin
                    clear_frame();
                end
            end
            GET_LEN: begin
                if (int'(b) < MIN_FRAME_BYTES || int'(b) > MAX_FRAME_BYTES) begin
                    res.item_kind = KIND_STATUS;
                    res.status    = ST_LEN_ERR;
                    res.last      = 1'b1;
                    produced      = 1'b1;
                    clear_frame();
                end else begin
                    dec_length = b;
                    add_byte(b);
                    dec_phase = GET_INDEX;
                end
            end
            GET_INDEX: begin
                dec_index = b;
                add_byte(b);
                dec_phase = GET_SYS;
            end
            GET_SYS: begin
                add_byte(b);
                dec_phase = GET_MOD;
            end
            GET_MOD: begin
                add_byte(b);
                dec_phase = GET_KIND;
            end
            GET_KIND: begin
                dec_kind = b;
                add_byte(b);
                dec_phase = (int'(dec_length) == MIN_FRAME_BYTES) ? GET_SUM_LO : GET_PAYLOAD;
            end
            GET_PAYLOAD: begin
                res.item_kind      = KIND_PAYLOAD;
                res.payload_byte   = b;
                res.payload_offset = dec_count - BYTE_W'(HEADER_BYTES);
                res.message_kind   = dec_kind;
                res.frame_number   = dec_index;
                produced           = 1'b1;
                add_byte(b);
                if (int'(dec_count) + 2 >= int'(dec_length)) dec_phase = GET_SUM_LO;
            end
            GET_SUM_LO: begin
                dec_sum_lo = b;
                dec_phase  = GET_SUM_HI;
            end
            GET_SUM_HI: begin
                got_sum          = {b, dec_sum_lo};
                res.item_kind    = KIND_STATUS;
                res.message_kind = dec_kind;
                res.frame_number = dec_index;
                res.last         = 1'b1;
                if (got_sum != dec_sum) begin
                    res.status = ST_SUM_ERR;
                end else if (dec_kind == KIND_A || dec_kind == KIND_B || dec_kind == KIND_C) begin
                    res.status = ST_GOOD;
                end else begin
                    res.status = ST_UNKNOWN;
                end
                produced = 1'b1;
                clear_frame();
            end
            default: begin
                clear_frame();
            end
        endcase
        if (produced) pending_results.insert(pending_results.size(), pin ? want : res);
    endtask

    task automatic check_result();
        t_res want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 16'd1, 16'd0);
        end else begin
            want = pending_results.pop_front();
            if (res_ch.item_kind !== want.item_kind)
                report_mismatch("item_kind", 16'(res_ch.item_kind), 16'(want.item_kind));
            if (res_ch.payload_byte !== want.payload_byte)
                report_mismatch("payload_byte", 16'(res_ch.payload_byte),
                                16'(want.payload_byte));
            if (res_ch.payload_offset !== want.payload_offset)
                report_mismatch("payload_offset", 16'(res_ch.payload_offset),
                                16'(want.payload_offset));
            if (res_ch.message_kind !== want.message_kind)
                report_mismatch("message_kind", 16'(res_ch.message_kind),
                                16'(want.message_kind));
            if (res_ch.frame_number !== want.frame_number)
                report_mismatch("frame_number", 16'(res_ch.frame_number),
                                16'(want.frame_number));
            if (res_ch.status !== want.status)
                report_mismatch("status", 16'(res_ch.status), 16'(want.status));
            if (res_ch.last !== want.last)
                report_mismatch("last", 16'(res_ch.last), 16'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (res_ch.valid && res_ch.ready) begin
                check_result();
                idle_cycles = 0;
            end
            if (rx_ch.valid && rx_ch.ready) begin
                frame_step(rx_ch.rx_byte, row_pinned, row_want);
                idle_cycles = 0;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_SYNC_FIRST) begin
                    sync_first_q = cfg_ch.data;
                end else if (cfg_ch.index == CFG_SYNC_SECOND) begin
                    sync_second_q = cfg_ch.data;
                end
                idle_cycles = 0;
            end
        end
    end

    // result side stall pattern
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 96);
        end
        ready_left--;
        ready_tick = ready_tick + 3'd1;
        case (ready_mode)
            READY_ALWAYS:   res_ch.ready <= 1'b1;
            READY_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   res_ch.ready <= ($urandom_range(0, 3) == 0);
            default:        res_ch.ready <= ~ready_tick[2];
        endcase
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                rx_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge i_clk); while (!rx_ch.ready);
        @(negedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_frames_done();
        rx_ch.valid = 1'b0;
        burst_left  = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(inout bit long_used);
        logic [BYTE_W-1:0] noise;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] kind;
        logic [BYTE_W-1:0] b;
        logic [SUM_W-1:0]  sum;
        int                pick;
        // line noise that cannot start a frame
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do noise = BYTE_W'($urandom); while (noise == sync_first_q);
                send_byte(noise);
            end
        end
        // start pattern broken after its first byte
        if ($urandom_range(0, 9) == 0) begin
            do noise = BYTE_W'($urandom);
            while (noise == sync_first_q || noise == sync_second_q);
            send_byte(sync_first_q);
            send_byte(noise);
        end
        send_byte(sync_first_q);
        if (sync_first_q != sync_second_q && $urandom_range(0, 9) == 0) send_byte(sync_first_q);
        send_byte(sync_second_q);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            len = BYTE_W'($urandom_range(0, MIN_FRAME_BYTES - 1));
        end else if (pick < 10 && !long_used) begin
            len       = BYTE_W'(MAX_FRAME_BYTES);
            long_used = 1'b1;
        end else if (pick < 20) begin
            len = BYTE_W'($urandom_range(MIN_FRAME_BYTES, 80));
        end else begin
            len = BYTE_W'($urandom_range(MIN_FRAME_BYTES, 24));
        end
        send_byte(len);
        if (int'(len) >= MIN_FRAME_BYTES) begin
            case ($urandom_range(0, 4))
                0:       kind = KIND_A;
                1:       kind = KIND_B;
                2:       kind = KIND_C;
                default: kind = BYTE_W'($urandom);
            endcase
            sum = SUM_W'(sync_first_q) + SUM_W'(sync_second_q) + SUM_W'(len) + SUM_W'(kind);
            repeat (3) begin
                b   = BYTE_W'($urandom);
                sum = sum + SUM_W'(b);
                send_byte(b);
            end
            send_byte(kind);
            repeat (int'(len) - MIN_FRAME_BYTES) begin
                b   = BYTE_W'($urandom);
                sum = sum + SUM_W'(b);
                send_byte(b);
            end
            if ($urandom_range(0, 6) == 0) sum = sum ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
            send_byte(sum[7:0]);
            send_byte(sum[15:8]);
        end
    endtask

    initial begin
        int setting;
        int target;
        bit long_used;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
        row_pinned     = 1'b0;
        row_want       = NO_RES;
        sync_first_q   = SYNC_FIRST_RST;
        sync_second_q  = SYNC_SECOND_RST;
        clear_frame();
        first_vals     = '{SYNC_FIRST_RST, 8'h00, 8'hFF, 8'h5A, 8'h00};
        second_vals    = '{SYNC_SECOND_RST, 8'hFF, 8'h00, 8'h5A, 8'h00};
        first_vals[4]  = BYTE_W'($urandom);
        second_vals[4] = BYTE_W'($urandom);
        directed_rows = '{
            // repeated first sync byte, then a zero length
            '{8'hFE, 1'b0, NO_RES}, '{8'hFE, 1'b0, NO_RES}, '{8'hEF, 1'b0, NO_RES},
            '{8'h00, 1'b1, LEN_ERR_RES},
            // hunt restart on a bad second byte
            '{8'hFE, 1'b0, NO_RES}, '{8'h34, 1'b0, NO_RES},
            // shortest frame, no payload, good sum
            '{8'hFE, 1'b0, NO_RES}, '{8'hEF, 1'b0, NO_RES}, '{8'h09, 1'b0, NO_RES},
            '{8'h07, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES},
            '{8'h10, 1'b0, NO_RES}, '{8'h10, 1'b0, NO_RES}, '{8'h02, 1'b1, EMPTY_RES},
            // one payload byte, all-ones index and kind, bad sum
            '{8'hFE, 1'b0, NO_RES}, '{8'hEF, 1'b0, NO_RES}, '{8'h0A, 1'b0, NO_RES},
            '{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
            '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
            '{8'h00, 1'b1, SUM_ERR_RES}
        };
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            row_pinned = directed_rows[r].pinned;
            row_want   = directed_rows[r].want;
            send_byte(directed_rows[r].rx_byte);
        end
        row_pinned = 1'b0;
        row_want   = NO_RES;

        for (setting = 0; setting < SETTINGS_RUN; setting++) begin
            if (setting != 0) begin
                wait_frames_done();
                write_reg(CFG_SYNC_FIRST, first_vals[setting]);
                write_reg(CFG_SYNC_SECOND, second_vals[setting]);
            end
            long_used = 1'b0;
            target    = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < target) send_frame(long_used);
        end

        wait_frames_done();
        if (mismatch_count == 0) begin
            $display("sync_length_sum_frame_receiver: match");
        end else begin
            $display("sync_length_sum_frame_receiver: mismatch");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_CYCLES);
        report_mismatch("watchdog, results pending", 16'(pending_results.size()), 16'd0);
        $display("sync_length_sum_frame_receiver: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/slsfr_pkg.sv
rtl/slsfr_if.sv
rtl/slsfr_front.sv
rtl/slsfr_queue.sv
rtl/slsfr_back.sv
rtl/sync_length_sum_frame_receiver.sv
sim/sync_length_sum_frame_receiver_test.sv
